### src/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Types, constants and helpers shared by the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int PAT_LEN_W       = 5;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

### src/wgm_if.sv
// ----------------------------------------------------------------------------
// wgm_if
// Valid/ready channels for text items and match results.
// ----------------------------------------------------------------------------
interface wgm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       has_symbol;
    logic       end_of_text;

    modport source (output valid, output symbol, output has_symbol,
                    output end_of_text, input ready);
    modport sink   (input valid, input symbol, input has_symbol,
                    input end_of_text, output ready);
endinterface

interface wgm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

### src/wgm_front.sv
// ----------------------------------------------------------------------------
// wgm_front
// Accepts text items, drops empty ones and queues the rest for the matcher.
// ----------------------------------------------------------------------------
module wgm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    wgm_text_if.sink             text_in,
    input  logic                 pop,
    output wgm_pkg::queue_head_t head
);

    wgm_pkg::item_t                       mem [wgm_pkg::QUEUE_DEPTH];
    logic [wgm_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [wgm_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [wgm_pkg::QUEUE_CNT_W-1:0]      count_reg, count_next;
    logic                                 accept;
    logic                                 push;
    logic                                 do_pop;
    wgm_pkg::item_t                       in_item;

    assign text_in.ready = (count_reg != wgm_pkg::QUEUE_CNT_W'(wgm_pkg::QUEUE_DEPTH));
    assign accept        = text_in.valid && text_in.ready;
    assign push          = accept && (text_in.has_symbol || text_in.end_of_text);
    assign do_pop        = pop && (count_reg != '0);

    assign in_item.symbol      = text_in.symbol;
    assign in_item.has_symbol  = text_in.has_symbol;
    assign in_item.end_of_text = text_in.end_of_text;

    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/wgm_back.sv
// ----------------------------------------------------------------------------
// wgm_back
// Advances the live pattern position set and registers the verdict.
// ----------------------------------------------------------------------------
module wgm_back #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]     pat_low,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]     pat_high,
    input  logic [wgm_pkg::PAT_LEN_W-1:0]      pat_len,
    input  wgm_pkg::queue_head_t               head,
    output logic                               pop,
    wgm_result_if.source                       result_out
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int SET_W = PATTERN_MAX + 1;

    logic [7:0]             pat_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] star;
    logic [PATTERN_MAX-1:0] any_hit;
    logic [PATTERN_MAX-1:0] in_use;
    logic [LEN_W-1:0]       lim;
    logic [LEN_W-1:0]       eff_len;
    logic [SET_W-1:0]       live_reg, live_next;
    logic [SET_W-1:0]       closed;
    logic [SET_W-1:0]       advanced;
    logic [SET_W-1:0]       tail_ok;
    logic [SET_W-1:0]       verdict_set;
    logic                   out_valid_reg, out_valid_next;
    logic                   matched_reg, matched_next;
    logic                   out_free;
    logic [7:0]             sym_fold;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_bytes
        if (g < 8)
        begin : g_low
            assign pat_byte[g] = pat_low[8*g +: 8];
        end
        else
        begin : g_high
            assign pat_byte[g] = pat_high[8*(g-8) +: 8];
        end
    end

    assign sym_fold = wgm_pkg::fold_case(head.item.symbol);

    always_comb
    begin
        if (pat_len > wgm_pkg::PAT_LEN_W'(PATTERN_MAX))
        begin
            lim = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            lim = LEN_W'(pat_len);
        end
        eff_len = lim;
        for (int i = PATTERN_MAX - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < lim && pat_byte[i] == 8'h00)
            begin
                eff_len = LEN_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            in_use[i]  = (LEN_W'(i) < eff_len);
            star[i]    = (pat_byte[i] == wgm_pkg::STAR_CHAR);
            any_hit[i] = (pat_byte[i] == wgm_pkg::ANY_CHAR) ||
                         (wgm_pkg::fold_case(pat_byte[i]) == sym_fold);
        end
    end

    always_comb
    begin
        closed[0] = live_reg[0];
        for (int i = 1; i < SET_W; i++)
        begin
            closed[i] = (live_reg[i] && (LEN_W'(i) <= eff_len)) ||
                        (closed[i-1] && in_use[i-1] && star[i-1]);
        end
    end

    always_comb
    begin
        advanced = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (closed[i] && in_use[i])
            begin
                if (star[i])
                begin
                    advanced[i] = 1'b1;
                end
                else if (any_hit[i])
                begin
                    advanced[i+1] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        tail_ok[PATTERN_MAX] = (eff_len == LEN_W'(PATTERN_MAX));
        for (int j = PATTERN_MAX - 1; j >= 0; j--)
        begin
            tail_ok[j] = (eff_len == LEN_W'(j)) ||
                         (in_use[j] && star[j] && tail_ok[j+1]);
        end
    end

    assign verdict_set = head.item.has_symbol ? advanced : live_reg;
    assign out_free    = !out_valid_reg || result_out.ready;
    assign pop         = head.valid && (!head.item.end_of_text || out_free);

    always_comb
    begin
        live_next      = live_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        matched_next   = matched_reg;
        if (pop)
        begin
            if (head.item.has_symbol)
            begin
                live_next = advanced;
            end
            if (head.item.end_of_text)
            begin
                live_next      = SET_W'(1);
                out_valid_next = 1'b1;
                matched_next   = |(verdict_set & tail_ok);
            end
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.matched = matched_reg;

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= SET_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streams text items against a stored '*'/'?' pattern, case-insensitive.
//
//   channel     dir   handshake      payload
//   text_in     in    valid/ready    symbol, has_symbol, end_of_text
//   result_out  out   valid/ready    matched
//   cfg         in    cfg_we         cfg_index, cfg_data
//
// One item per cycle sustained while results are taken; the position-set
// update is combinational logic in the matcher stage. A verdict is registered
// once its end item is queued and popped. A four-entry queue between front
// and matcher absorbs result-side stalls; text_in.ready drops only when it is
// full. Reset clears the pattern registers, the queue and the live set.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wgm_text_if.sink                         text_in,
    wgm_result_if.source                     result_out,
    input  logic                             cfg_we,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [wgm_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [wgm_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [wgm_pkg::PAT_LEN_W-1:0]  pat_len_reg;
    wgm_pkg::queue_head_t           head;
    logic                           pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (wgm_pkg::cfg_index_t'(cfg_index))
                wgm_pkg::CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                wgm_pkg::CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                wgm_pkg::CFG_PAT_LEN:  pat_len_reg  <= cfg_data[wgm_pkg::PAT_LEN_W-1:0];
                default:               ;
            endcase
        end
    end

    wgm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .pop     (pop),
        .head    (head)
    );

    wgm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pat_low    (pat_low_reg),
        .pat_high   (pat_high_reg),
        .pat_len    (pat_len_reg),
        .head       (head),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

### dv/wildcard_glob_matcher_tb.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_tb
// Self-checking bench for the streaming '*'/'?' glob matcher. A directed
// table covers reset values, register extremes, terminators, case folding
// and a pattern change in mid-string. Random phases follow: a fresh pattern
// per phase and strings grown from it, mutated or pure noise. A local model
// of the live position set predicts every verdict the table does not give.
// Both channels idle at random, and now and then the result side holds off
// long enough to back up the input.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wgm_pkg::*;

    localparam int PAT_MAX      = PATTERN_MAX_DEF;
    localparam int ITEM_TARGET  = 580;
    localparam int CALM_ITEMS   = 110;
    localparam int CFG_SETTLE   = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 10000;
    localparam int TAIL_CYCLES  = 20;
    localparam int TIMEOUT_NS   = 1000000;

    typedef enum logic { ROW_CFG, ROW_TEXT } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        cfg_index_t  idx;
        logic [63:0] data;
        logic [7:0]  sym;
        logic        hs;
        logic        eot;
        logic        typed;
        logic        want;
    } dir_row_t;

    localparam int DIR_ROWS = 32;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
        '{ROW_CFG,  CFG_PAT_LOW,  64'h0000_0000_423F_2A61, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_LEN,  64'd4,                   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h78, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h62, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'hC3, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h51, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h52, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h42, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h5A, 1'b0, 1'b1, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_LEN,  64'd31,                  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_LOW,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_HIGH, 64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h7A, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
        '{ROW_CFG,  CFG_PAT_LOW,  64'h0000_0000_0000_5A3F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_HIGH, 64'h0,                   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_LEN,  64'd16,                  8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h7A, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG,  CFG_PAT_LEN,  64'd1,                   8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ROW_TEXT, CFG_PAT_LOW,  64'h0,                   8'h00, 1'b0, 1'b1, 1'b0, 1'b0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wgm_text_if   text_bus ();
    wgm_result_if result_bus ();

    wildcard_glob_matcher #(
        .PATTERN_MAX (PAT_MAX)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_bus),
        .result_out (result_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len_reg;
    logic [16:0] live_set;

    logic verdict_q [$];
    int   errors;
    int   checked;
    int   items_sent;
    int   reg_writes;
    bit   idle_on;
    bit   hold_req;

    function automatic logic [7:0] pat_byte(input int i);
        logic [7:0] b;
        b = 8'h00;
        if (i < 8)
        begin
            b = pat_lo[8*i +: 8];
        end
        else if (i < 16)
        begin
            b = pat_hi[8*(i-8) +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            u = c - 8'h20;
        end
        return u;
    endfunction

    function automatic int active_len();
        int lim;
        int i;
        lim = pat_len_reg;
        if (lim > PAT_MAX)
        begin
            lim = PAT_MAX;
        end
        for (i = 0; i < lim; i++)
        begin
            if (pat_byte(i) == 8'h00)
            begin
                return i;
            end
        end
        return lim;
    endfunction

    function automatic logic [16:0] star_closure(input logic [16:0] s, input int n);
        logic [16:0] r;
        int i;
        r = s;
        for (i = 0; i < 17; i++)
        begin
            if (i > n)
            begin
                r[i] = 1'b0;
            end
        end
        for (i = 0; i < n; i++)
        begin
            if (r[i] && pat_byte(i) == STAR_CHAR)
            begin
                r[i+1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] step_set(input logic [16:0] s, input int n,
                                             input logic [7:0] c);
        logic [16:0] nx;
        logic [7:0]  p;
        int i;
        nx = '0;
        for (i = 0; i < n; i++)
        begin
            if (s[i])
            begin
                p = pat_byte(i);
                if (p == STAR_CHAR)
                begin
                    nx[i] = 1'b1;
                end
                else if (p == ANY_CHAR || upcase(p) == upcase(c))
                begin
                    nx[i+1] = 1'b1;
                end
            end
        end
        return nx;
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: c = 8'h41 + 8'($urandom_range(0, 25));
            4, 5:       c = 8'h61 + 8'($urandom_range(0, 25));
            6:          c = 8'h30 + 8'($urandom_range(0, 9));
            default:    c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic glob_predict(input logic [7:0] sym, input logic hs, input logic eot,
                                output bit has_res, output logic verdict);
        int n;
        logic [16:0] closed;
        n = active_len();
        verdict = 1'b0;
        if (hs)
        begin
            live_set = step_set(star_closure(live_set, n), n, sym);
        end
        has_res = eot;
        if (eot)
        begin
            closed = star_closure(live_set, n);
            verdict = closed[n];
            live_set = 17'd1;
        end
    endtask

    task automatic send_item(input logic [7:0] sym, input logic hs, input logic eot,
                             input logic typed, input logic want);
        int   gap;
        bit   got;
        logic v;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            text_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_bus.valid       <= 1'b1;
        text_bus.symbol      <= sym;
        text_bus.has_symbol  <= hs;
        text_bus.end_of_text <= eot;
        do
            @(posedge clk);
        while (text_bus.ready !== 1'b1);
        glob_predict(sym, hs, eot, got, v);
        if (got)
        begin
            verdict_q.push_back(typed ? want : v);
        end
        if (hs || eot)
        begin
            items_sent++;
        end
    endtask

    task automatic settle();
        text_bus.valid <= 1'b0;
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PAT_LOW:  pat_lo = data;
            CFG_PAT_HIGH: pat_hi = data;
            CFG_PAT_LEN:  pat_len_reg = data[4:0];
            default:      ;
        endcase
        reg_writes++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout: %0d verdicts still outstanding", verdict_q.size());
        $display("wildcard_glob_matcher_tb: errors");
        $finish;
    end

    initial
    begin
        int   burst;
        int   hold_left;
        logic want;
        burst     = 0;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result: matched=%b", result_bus.matched);
                    end
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result_bus.matched !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("verdict %0d mismatch: expected matched=%b, got %b",
                                     checked, want, result_bus.matched);
                        end
                    end
                    checked++;
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                result_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 5) - 1;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        bit          settled;
        int          i;
        int          j;
        int          k;
        int          n;
        int          nstr;
        int          plen;
        bit          unfinished;
        bit          end_with_sym;
        logic [7:0]  c;
        logic [63:0] new_lo;
        logic [63:0] new_hi;
        logic [7:0]  text_q [$];

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_PAT_LOW;
        cfg_data             <= '0;
        text_bus.valid       <= 1'b0;
        text_bus.symbol      <= 8'h00;
        text_bus.has_symbol  <= 1'b0;
        text_bus.end_of_text <= 1'b0;
        pat_lo      = '0;
        pat_hi      = '0;
        pat_len_reg = '0;
        live_set    = 17'd1;
        errors      = 0;
        checked     = 0;
        items_sent  = 0;
        reg_writes  = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        settled     = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_tab[k].kind == ROW_CFG)
            begin
                if (!settled)
                begin
                    settle();
                end
                write_reg(dir_tab[k].idx, dir_tab[k].data);
                settled = 1'b1;
            end
            else
            begin
                send_item(dir_tab[k].sym, dir_tab[k].hs, dir_tab[k].eot,
                          dir_tab[k].typed, dir_tab[k].want);
                settled = 1'b0;
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            settle();
            new_lo = '0;
            new_hi = '0;
            for (i = 0; i < 16; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: c = STAR_CHAR;
                    3, 4:    c = ANY_CHAR;
                    9:       c = 8'($urandom_range(0, 255));
                    default: c = pick_char();
                endcase
                if (i < 8)
                begin
                    new_lo[8*i +: 8] = c;
                end
                else
                begin
                    new_hi[8*(i-8) +: 8] = c;
                end
            end
            if ($urandom_range(0, 9) == 0)
            begin
                i = $urandom_range(0, 15);
                if (i < 8)
                begin
                    new_lo[8*i +: 8] = 8'h00;
                end
                else
                begin
                    new_hi[8*(i-8) +: 8] = 8'h00;
                end
            end
            case ($urandom_range(0, 9))
                8:       plen = $urandom_range(7, 16);
                9:       plen = $urandom_range(17, 31);
                default: plen = $urandom_range(0, 6);
            endcase
            write_reg(CFG_PAT_LOW, new_lo);
            write_reg(CFG_PAT_HIGH, new_hi);
            write_reg(CFG_PAT_LEN, 64'(plen));

            nstr = $urandom_range(2, 6);
            if (nstr >= 4 && items_sent < ITEM_TARGET - 2 * CALM_ITEMS)
            begin
                hold_req = 1'b1;
            end
            for (k = 0; k < nstr; k++)
            begin
                idle_on = (items_sent < ITEM_TARGET - CALM_ITEMS);
                text_q.delete();
                if ($urandom_range(0, 5) == 0)
                begin
                    n = $urandom_range(0, 6);
                    for (i = 0; i < n; i++)
                    begin
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    n = active_len();
                    for (i = 0; i < n; i++)
                    begin
                        c = pat_byte(i);
                        if (c == STAR_CHAR)
                        begin
                            plen = $urandom_range(0, 3);
                            for (j = 0; j < plen; j++)
                            begin
                                text_q.push_back(pick_char());
                            end
                        end
                        else if (c == ANY_CHAR)
                        begin
                            text_q.push_back(pick_char());
                        end
                        else
                        begin
                            if (upcase(c) >= 8'h41 && upcase(c) <= 8'h5A &&
                                $urandom_range(0, 1) == 1)
                            begin
                                c = c ^ 8'h20;
                            end
                            text_q.push_back(c);
                        end
                    end
                    case ($urandom_range(0, 7))
                        0, 1:
                        begin
                            if (text_q.size() > 0)
                            begin
                                text_q[$urandom_range(0, text_q.size() - 1)] = pick_char();
                            end
                        end
                        2:
                        begin
                            if (text_q.size() > 0)
                            begin
                                void'(text_q.pop_back());
                            end
                        end
                        3:       text_q.push_back(pick_char());
                        default: ;
                    endcase
                end
                unfinished   = (k == nstr - 1) && ($urandom_range(0, 4) == 0);
                end_with_sym = ($urandom_range(0, 1) == 1);
                for (j = 0; j < text_q.size(); j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0);
                    end
                    send_item(text_q[j], 1'b1,
                              (j == text_q.size() - 1) && end_with_sym && !unfinished,
                              1'b0, 1'b0);
                end
                if (!unfinished && (!end_with_sym || text_q.size() == 0))
                begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0);
                end
            end
        end

        text_bus.valid <= 1'b0;
        n = 0;
        while (verdict_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            errors += verdict_q.size();
            $display("%0d verdicts never arrived", verdict_q.size());
        end

        $display("ran %0d text items through %0d register writes, %0d verdicts checked",
                 items_sent, reg_writes, checked);
        $display("mismatches: %0d", errors);
        if (errors == 0)
        begin
            $display("wildcard_glob_matcher_tb: clean");
        end
        else
        begin
            $display("wildcard_glob_matcher_tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
src/wgm_pkg.sv
src/wgm_if.sv
src/wgm_front.sv
src/wgm_back.sv
src/wildcard_glob_matcher.sv
dv/wildcard_glob_matcher_tb.sv
